### rtl/core/dmc_pkg.sv
// Shared constants for the direct-mapped cache access core.
// Holds the memory and cache geometry, the derived widths and the outcome codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dmc_pkg;

  // Geometry: all three sizes are powers of two, so address splits are bit slices
  localparam int MEM_WORDS   = 1024;
  localparam int CACHE_WORDS = 64;
  localparam int BLOCK_WORDS = 4;
  localparam int NUM_LINES   = (CACHE_WORDS / BLOCK_WORDS) > 0 ?
                               (CACHE_WORDS / BLOCK_WORDS) : 1;

  // Widths, most of them derived from the geometry
  localparam int ADDR_W  = 10;
  localparam int DATA_W  = 32;
  localparam int MEM_AW  = $clog2(MEM_WORDS);
  localparam int CACHE_AW = $clog2(CACHE_WORDS);
  localparam int OFF_W   = $clog2(BLOCK_WORDS);
  localparam int LINE_W  = $clog2(NUM_LINES);
  localparam int TAG_W   = MEM_AW - CACHE_AW;
  localparam int CNT_W   = OFF_W + 1;

  // Fill counter limits and main memory initialisation constants
  localparam logic [CNT_W-1:0] BLOCK_CNT = BLOCK_WORDS[CNT_W-1:0];
  localparam logic [OFF_W-1:0] LAST_OFF  = OFF_W'(BLOCK_WORDS - 1);
  localparam logic [MEM_AW-1:0] LAST_WORD = MEM_AW'(MEM_WORDS - 1);
  localparam logic [DATA_W-1:0] MEM_INIT_BASE = DATA_W'(MEM_WORDS);

  // Access kinds
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Outcome codes
  localparam logic [1:0] OUTCOME_HIT  = 2'd0;
  localparam logic [1:0] OUTCOME_COMP = 2'd1;
  localparam logic [1:0] OUTCOME_CONF = 2'd2;

endpackage

`default_nettype wire

### rtl/core/direct_mapped_cache_access_core.sv
// Direct-mapped cache in front of a word-addressed main memory, one access per beat.
// Uses dmc_pkg for geometry, widths and outcome codes.
`timescale 1ns / 1ps
`default_nettype none

// After reset the block sweeps all MEM_WORDS (1024) words of main memory so that
// word i holds MEM_WORDS + i; s_tready stays low during this sweep. Then it takes one
// access at a time: a hit read passes through tag check, cache read and result, and a
// hit write through tag check with the cache write and result; a miss passes through
// tag check, a block fill through the single main memory read port at one word per
// cycle via its registered read, then result. The result waits in an output register
// until m_tready; the next beat can be taken in the cycle after the result is taken.
// A miss always reports the word at the requested address after the access: on a
// conflict write, memory is written first and the refilled block carries the new
// value. Hits never write back to memory.
module direct_mapped_cache_access_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // Request beat
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // [9:0] address, [41:10] write_data, [47:42] zero
  input  wire logic        s_tuser,   // [0] op
  // Result beat
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // [3:0] tag, [7:4] line, [9:8] word_offset,
                                      // [41:10] data, [47:42] zero
  output logic [1:0]       m_tuser    // [1:0] outcome
);

  localparam logic [2:0] ST_INIT = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_LOOK = 3'd2;
  localparam logic [2:0] ST_FILL = 3'd3;
  localparam logic [2:0] ST_HRD  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  // Sequencer and request registers
  logic [2:0]                       state;
  logic [dmc_pkg::MEM_AW-1:0]       init_cnt;
  logic                             op;
  logic [dmc_pkg::MEM_AW-1:0]       addr;
  logic [dmc_pkg::DATA_W-1:0]       wdata;
  logic [1:0]                       outcome;
  logic [dmc_pkg::DATA_W-1:0]       data;
  logic [dmc_pkg::CNT_W-1:0]        cnt;
  logic                             rd_valid;
  logic [dmc_pkg::OFF_W-1:0]        rd_off;

  // Line state: valid bits in flops, tags without reset
  logic [dmc_pkg::NUM_LINES-1:0]    line_valid;
  logic [dmc_pkg::TAG_W-1:0]        line_tag [dmc_pkg::NUM_LINES];

  // Memories
  logic [dmc_pkg::DATA_W-1:0]       memory_words [dmc_pkg::MEM_WORDS];
  logic [dmc_pkg::DATA_W-1:0]       line_data [dmc_pkg::CACHE_WORDS];

  logic                             mem_we;
  logic [dmc_pkg::MEM_AW-1:0]       mem_waddr;
  logic [dmc_pkg::DATA_W-1:0]       mem_wdata;
  logic [dmc_pkg::MEM_AW-1:0]       mem_raddr;
  logic [dmc_pkg::DATA_W-1:0]       mem_rdata;

  logic                             cache_we;
  logic [dmc_pkg::CACHE_AW-1:0]     cache_waddr;
  logic [dmc_pkg::DATA_W-1:0]       cache_wdata;
  logic [dmc_pkg::CACHE_AW-1:0]     cache_raddr;
  logic [dmc_pkg::DATA_W-1:0]       cache_rdata;

  // Address split
  logic [dmc_pkg::TAG_W-1:0]        tag_f;
  logic [dmc_pkg::LINE_W-1:0]       line_f;
  logic [dmc_pkg::OFF_W-1:0]        off_f;
  logic                             is_valid;
  logic                             tag_eq;
  logic                             rd_issue;
  logic                             rd_hit_off;
  logic [dmc_pkg::MEM_AW-1:0]       in_addr;

  assign in_addr = s_tdata[dmc_pkg::MEM_AW-1:0];
  assign tag_f   = addr[dmc_pkg::MEM_AW-1:dmc_pkg::CACHE_AW];
  assign line_f  = addr[dmc_pkg::CACHE_AW-1:dmc_pkg::OFF_W];
  assign off_f   = addr[dmc_pkg::OFF_W-1:0];

  assign is_valid   = line_valid[line_f];
  assign tag_eq     = (line_tag[line_f] == tag_f);
  assign rd_issue   = (state == ST_FILL) && (cnt < dmc_pkg::BLOCK_CNT);
  assign rd_hit_off = (rd_off == off_f);

  // Drive the memory ports from the sequencer
  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = addr;
    mem_wdata   = wdata;
    mem_raddr   = {addr[dmc_pkg::MEM_AW-1:dmc_pkg::OFF_W], cnt[dmc_pkg::OFF_W-1:0]};
    cache_we    = 1'b0;
    cache_waddr = {line_f, off_f};
    cache_wdata = wdata;
    cache_raddr = {line_f, off_f};
    case (state)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = init_cnt;
        mem_wdata = dmc_pkg::MEM_INIT_BASE + dmc_pkg::DATA_W'(init_cnt);
      end
      ST_LOOK: begin
        if (is_valid && tag_eq) begin
          cache_we = (op == dmc_pkg::OP_WRITE);
        end else if (is_valid) begin
          mem_we = (op == dmc_pkg::OP_WRITE);
        end
      end
      ST_FILL: begin
        cache_we    = rd_valid;
        cache_waddr = {line_f, rd_off};
        if (outcome == dmc_pkg::OUTCOME_COMP && op == dmc_pkg::OP_WRITE && rd_hit_off) begin
          cache_wdata = wdata;
        end else begin
          cache_wdata = mem_rdata;
        end
      end
      default: begin
      end
    endcase
  end

  // Main memory: one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      memory_words[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= memory_words[mem_raddr];
  end

  // Cache data store: one write and one registered read port
  always_ff @(posedge clk) begin
    if (cache_we) begin
      line_data[cache_waddr] <= cache_wdata;
    end
    cache_rdata <= line_data[cache_raddr];
  end

  // Tag store: written when a fill completes
  always_ff @(posedge clk) begin
    if (state == ST_FILL && rd_valid && rd_off == dmc_pkg::LAST_OFF) begin
      line_tag[line_f] <= tag_f;
    end
  end

  // Capture the request beat
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op    <= s_tuser;
      addr  <= in_addr;
      wdata <= s_tdata[dmc_pkg::MEM_AW +: dmc_pkg::DATA_W];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      init_cnt   <= '0;
      cnt        <= '0;
      rd_valid   <= 1'b0;
      line_valid <= '0;
    end else begin
      rd_valid <= rd_issue;
      if (rd_issue) begin
        rd_off <= cnt[dmc_pkg::OFF_W-1:0];
        cnt    <= cnt + 1'b1;
      end
      case (state)
        ST_INIT: begin
          init_cnt <= init_cnt + 1'b1;
          if (init_cnt == dmc_pkg::LAST_WORD) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          cnt <= '0;
          if (is_valid && tag_eq) begin
            outcome <= dmc_pkg::OUTCOME_HIT;
            if (op == dmc_pkg::OP_WRITE) begin
              data  <= wdata;
              state <= ST_OUT;
            end else begin
              state <= ST_HRD;
            end
          end else begin
            outcome <= is_valid ? dmc_pkg::OUTCOME_CONF : dmc_pkg::OUTCOME_COMP;
            state   <= ST_FILL;
          end
        end
        ST_FILL: begin
          // Pick up the requested word as it streams in
          if (rd_valid && rd_hit_off) begin
            data <= (op == dmc_pkg::OP_WRITE) ? wdata : mem_rdata;
          end
          if (rd_valid && rd_off == dmc_pkg::LAST_OFF) begin
            line_valid[line_f] <= 1'b1;
            state              <= ST_OUT;
          end
        end
        ST_HRD: begin
          data  <= cache_rdata;
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Handshake and result beat
  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_OUT);
  assign m_tuser  = outcome;
  assign m_tdata  = {6'd0, data, off_f, line_f, tag_f};

`ifndef SYNTHESIS
  // Never take a request while a result is pending
  a_ready_excl: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid)
    else $error("request taken while result pending");

  // An accepted beat goes straight to the tag check
  a_accept_look: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_LOOK))
    else $error("accepted beat did not reach tag check");

  // Fill read data only arrives inside a fill
  a_fill_data: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> (state == ST_FILL))
    else $error("fill data outside fill");

  // A delivered result always leaves its line valid with its tag
  a_line_after: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready) |-> (line_valid[line_f] && tag_eq))
    else $error("line not valid after access");

  // A hit needs a valid line
  a_hit_valid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HRD) |-> (outcome == dmc_pkg::OUTCOME_HIT && line_valid[line_f]))
    else $error("cache read without hit");
`endif

endmodule

`default_nettype wire
